/* src/pbw_pkg.sv */
package pbw_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned LEN_W     = 31;
	localparam int unsigned DIST_W    = 50;
	localparam int unsigned NUM_CELLS = COORD_W;
	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam logic [LEN_W-1:0]  LEN_RESET  = 31'd655360;
	localparam logic [2:0]        MASK_RESET = 3'b111;
	localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		REG_LEN_X = 2'd0,
		REG_LEN_Y = 2'd1,
		REG_LEN_Z = 2'd2,
		REG_MASK  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_WRAP = 1'b0,
		OP_DIST = 1'b1
	} op_t;

	typedef logic [2:0][LEN_W-1:0] len_vec_t;

	typedef struct packed {
		op_t                         op;
		logic [2:0][COORD_W-1:0]     a;
		logic [2:0][COORD_W-1:0]     mag;
		logic [2:0][LEN_W-1:0]       rem;
		logic [DIST_W-1:0]           dsq;
	} chain_t;

endpackage

/* src/pbw_cell.sv */
module pbw_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  pbw_pkg::chain_t   d_i,
	input  pbw_pkg::len_vec_t len,
	output logic              valid_o,
	output pbw_pkg::chain_t   d_o
);

	pbw_pkg::chain_t          nxt;
	logic [pbw_pkg::LEN_W:0]  t [3];

	// one restoring remainder step per axis
	always_comb begin
		nxt = d_i;
		for (int i = 0; i < 3; i++) begin
			t[i] = {d_i.rem[i], d_i.mag[i][BIT]};
			if (t[i] >= {1'b0, len[i]}) begin
				t[i] = t[i] - {1'b0, len[i]};
			end
			nxt.rem[i] = t[i][pbw_pkg::LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end

endmodule

/* src/pbw_dist.sv */
module pbw_dist #(
	parameter int unsigned FRAC_BITS = pbw_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_i,
	input  pbw_pkg::op_t                      op,
	input  logic [2:0][pbw_pkg::COORD_W-1:0]  a,
	input  logic [2:0][pbw_pkg::COORD_W-1:0]  b,
	input  pbw_pkg::len_vec_t                 len,
	output logic                              valid_o,
	output pbw_pkg::chain_t                   d_o
);

	localparam int unsigned CW = pbw_pkg::COORD_W;

	logic                     valid_s1, valid_s2, valid_s3;
	pbw_pkg::op_t             op_s1, op_s2, op_s3;
	logic [2:0][CW-1:0]       a_s1, b_s1, a_s2, a_s3;
	logic [2:0][CW-1:0]       m_s2, mag_s2, mag_s3;
	logic [2:0][2*CW-1:0]     sq_s3;

	logic signed [CW:0]       d     [3];
	logic signed [CW+1:0]     d2    [3];
	logic signed [CW+1:0]     ls    [3];
	logic signed [CW+1:0]     adj   [3];
	logic [CW+1:0]            am    [3];
	logic [2:0][CW-1:0]       m_c, mag_c;
	logic [2*CW+1:0]          sum;
	logic [2*CW+1:0]          q;
	logic [pbw_pkg::DIST_W-1:0] dist_c;

	// minimum-image shift and magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]   = $signed({a_s1[i][CW-1], a_s1[i]}) - $signed({b_s1[i][CW-1], b_s1[i]});
			d2[i]  = {d[i], 1'b0};
			ls[i]  = $signed({3'b000, len[i]});
			adj[i] = {d[i][CW], d[i]};
			if (d2[i] < -ls[i]) begin
				adj[i] = adj[i] + ls[i];
			end else if (d2[i] > ls[i]) begin
				adj[i] = adj[i] - ls[i];
			end
			am[i]    = adj[i][CW+1] ? (-adj[i]) : adj[i];
			m_c[i]   = am[i][CW-1:0];
			mag_c[i] = a_s1[i][CW-1] ? (-a_s1[i]) : a_s1[i];
		end
	end

	always_comb begin
		sum = {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
		q   = sum >> FRAC_BITS;
		if (op_s3 == pbw_pkg::OP_WRAP) begin
			dist_c = '0;
		end else if (q > {{(2*CW+2-pbw_pkg::DIST_W){1'b0}}, pbw_pkg::DIST_MAX}) begin
			dist_c = pbw_pkg::DIST_MAX;
		end else begin
			dist_c = q[pbw_pkg::DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_o  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op;
			a_s1   <= a;
			b_s1   <= b;
			op_s2  <= op_s1;
			a_s2   <= a_s1;
			m_s2   <= m_c;
			mag_s2 <= mag_c;
			op_s3  <= op_s2;
			a_s3   <= a_s2;
			mag_s3 <= mag_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= m_s2[i] * m_s2[i];
			end
			d_o.op   <= op_s3;
			d_o.a    <= a_s3;
			d_o.mag  <= mag_s3;
			d_o.rem  <= '0;
			d_o.dsq  <= dist_c;
		end
	end

endmodule

/* src/periodic_box_wrap_and_min_image.sv */
// Channel | Signals                               | Direction
// in      | in_valid/in_ready, op, ax..az, bx..bz | into block
// out     | out_valid/out_ready, wx, wy, wz, dist2 | out of block
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | into block
//
// Accepts one transaction per cycle while in_ready is high.
// The pipeline is four distance stages, the 32-cell remainder chain (one quotient bit
// per cell) and the output register.
// The whole pipeline advances together; when the output register holds and
// out_ready is low, in_ready drops and every stage holds.
// Reset clears valid bits and loads the register reset values; cfg_ready is always high.
module periodic_box_wrap_and_min_image #(
	parameter int unsigned FRAC_BITS = pbw_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic signed [31:0]  ax,
	input  logic signed [31:0]  ay,
	input  logic signed [31:0]  az,
	input  logic signed [31:0]  bx,
	input  logic signed [31:0]  by,
	input  logic signed [31:0]  bz,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  wx,
	output logic signed [31:0]  wy,
	output logic signed [31:0]  wz,
	output logic [49:0]         dist2,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int unsigned NC = pbw_pkg::NUM_CELLS;
	localparam int unsigned CW = pbw_pkg::COORD_W;

	pbw_pkg::len_vec_t        len_q;
	logic [2:0]               mask_q;
	logic                     en;
	logic [NC:0]              v;
	pbw_pkg::chain_t          c [NC+1];
	logic [2:0][CW-1:0]       w_c;
	logic [2:0][CW-1:0]       w_q;
	logic [pbw_pkg::DIST_W-1:0] dist_q;
	pbw_pkg::op_t             op_q;
	logic                     out_valid_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= {pbw_pkg::LEN_RESET, pbw_pkg::LEN_RESET, pbw_pkg::LEN_RESET};
			mask_q <= pbw_pkg::MASK_RESET;
		end else if (cfg_valid && cfg_index[31:2] == '0) begin
			case (pbw_pkg::reg_idx_t'(cfg_index[1:0]))
				pbw_pkg::REG_LEN_X: len_q[0] <= cfg_data[pbw_pkg::LEN_W-1:0];
				pbw_pkg::REG_LEN_Y: len_q[1] <= cfg_data[pbw_pkg::LEN_W-1:0];
				pbw_pkg::REG_LEN_Z: len_q[2] <= cfg_data[pbw_pkg::LEN_W-1:0];
				pbw_pkg::REG_MASK:  mask_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	pbw_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (in_valid && in_ready),
		.op      (pbw_pkg::op_t'(op)),
		.a       ({az, ay, ax}),
		.b       ({bz, by, bx}),
		.len     (len_q),
		.valid_o (v[0]),
		.d_o     (c[0])
	);

	for (genvar k = 0; k < NC; k++) begin : g_cell
		pbw_cell #(.BIT(NC - 1 - k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (v[k]),
			.d_i     (c[k]),
			.len     (len_q),
			.valid_o (v[k+1]),
			.d_o     (c[k+1])
		);
	end

	// pick the wrapped coordinate from the remainder of |a| by the length
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[i] = c[NC].a[i];
			if (c[NC].op == pbw_pkg::OP_WRAP && mask_q[i] && len_q[i] != '0) begin
				if (c[NC].a[i][CW-1]) begin
					w_c[i] = {1'b0, len_q[i]} - {1'b0, c[NC].rem[i]};
				end else if (c[NC].a[i] > {1'b0, len_q[i]}) begin
					w_c[i] = {1'b0, c[NC].rem[i]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_q    <= w_c;
			dist_q <= c[NC].dsq;
			op_q   <= c[NC].op;
		end
	end

	assign out_valid = out_valid_q;
	assign wx        = $signed(w_q[0]);
	assign wy        = $signed(w_q[1]);
	assign wz        = $signed(w_q[2]);
	assign dist2     = dist_q;

	a_wrap_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && op_q == pbw_pkg::OP_WRAP |-> dist_q == '0)
		else $error("wrap result carries nonzero distance");

	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v))
		else $error("pipeline moved while output stalled");

	a_wrap_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && op_q == pbw_pkg::OP_WRAP && mask_q[0] && len_q[0] != '0
		|-> !w_q[0][CW-1] && w_q[0] <= {1'b0, len_q[0]})
		else $error("wrapped x outside box");

endmodule
